// ===== design/fslm_pkg.sv =====
`default_nettype none
// Package of the fixed-slot free list manager: field widths, operation and status codes,
// register map and the configuration struct. It depends on nothing else.
package fslm_pkg;

  localparam int unsigned MaxSlotsDefault = 256;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned SlotW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 9;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CountW-1:0] SlotCountReset = 9'd256;

  typedef enum logic [ModeW-1:0] {
    ModeAlloc   = 2'd0,
    ModeFree    = 2'd1,
    ModeInit    = 2'd2,
    ModeRelease = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    StOk          = 3'd0,
    StNotInit     = 3'd1,
    StExhausted   = 3'd2,
    StBadSlot     = 3'd3,
    StNothingLent = 3'd4,
    StInUse       = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    RegSlotCount = 1'd0
  } reg_idx_e;

  typedef struct packed {
    logic [CountW-1:0] slot_count;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/fslm_if.sv =====
`default_nettype none
// Valid/ready channel interfaces for the request and response transfers.
// Depends on fslm_pkg for the field widths.
interface fslm_req_if;
  import fslm_pkg::*;
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [SlotW-1:0] slot_index;

  modport source (output valid, mode, slot_index, input ready);
  modport sink (input valid, mode, slot_index, output ready);
endinterface

interface fslm_rsp_if;
  import fslm_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [SlotW-1:0]   granted_slot;

  modport source (output valid, status, granted_slot, input ready);
  modport sink (input valid, status, granted_slot, output ready);
endinterface
`default_nettype wire

// ===== design/fslm_ram.sv =====
`default_nettype none
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package needed.
module fslm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/fslm_cfg.sv =====
`default_nettype none
// APB-style configuration register block holding the slot count.
// Depends on fslm_pkg for the register map and cfg_t.
module fslm_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [fslm_pkg::CfgAddrW-1:0]    paddr,
  input  wire logic [fslm_pkg::CfgDataW-1:0]    pwdata,
  output logic      [fslm_pkg::CfgDataW-1:0]    prdata,
  output logic                                  pready,
  output fslm_pkg::cfg_t                        cfg_o
);
  import fslm_pkg::*;

  logic [CountW-1:0] slot_count_q, slot_count_d;
  reg_idx_e          reg_idx;
  logic              wr_en;

  assign reg_idx = reg_idx_e'(paddr[CfgAddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    slot_count_d = slot_count_q;
    prdata       = '0;
    case (reg_idx)
      RegSlotCount: begin
        prdata = CfgDataW'(slot_count_q);
        if (wr_en) begin
          slot_count_d = pwdata[CountW-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SlotCountReset;
    end else begin
      slot_count_q <= slot_count_d;
    end
  end

  assign cfg_o.slot_count = slot_count_q;

endmodule
`default_nettype wire

// ===== design/fslm_engine.sv =====
`default_nettype none
// Free list sequencer: decodes each request, reads and updates the link memory and the
// head and count registers, and holds the response. Depends on fslm_pkg, fslm_if, fslm_ram.
module fslm_engine #(
  parameter int unsigned MAX_SLOTS = fslm_pkg::MaxSlotsDefault,
  parameter int unsigned AddrW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire fslm_pkg::cfg_t cfg_i,
  fslm_req_if.sink       req_i,
  fslm_rsp_if.source     rsp_o
);
  import fslm_pkg::*;

  localparam int unsigned CntMaxInt = (MAX_SLOTS > 511) ? 511 : MAX_SLOTS;
  localparam logic [CountW-1:0] CntMax = CountW'(CntMaxInt);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_INIT = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  mode_e              mode_q, mode_d;
  logic [SlotW-1:0]   idx_q, idx_d;
  logic [AddrW-1:0]   head_q, head_d;
  logic               head_valid_q, head_valid_d;
  logic [CountW-1:0]  lent_q, lent_d;
  logic [CountW-1:0]  live_q, live_d;
  logic               pool_live_q, pool_live_d;
  logic [CountW-1:0]  init_cnt_q, init_cnt_d;
  logic [CountW-1:0]  init_n_q, init_n_d;
  logic               rsp_valid_q, rsp_valid_d;
  status_e            status_q, status_d;
  logic [SlotW-1:0]   granted_q, granted_d;

  logic               mem_we, mem_re;
  logic [AddrW-1:0]   mem_waddr, mem_wdata, mem_rdata;

  logic               out_free, load_rsp, alloc_more;
  status_e            ld_status;
  logic [SlotW-1:0]   ld_granted;
  logic [CountW-1:0]  init_n, lent_inc, cnt_inc;

  fslm_ram #(
    .Width (AddrW),
    .Depth (MAX_SLOTS),
    .AddrW (AddrW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (head_q),
    .rdata_o (mem_rdata)
  );

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.granted_slot = granted_q;

  assign out_free   = !rsp_valid_q || rsp_o.ready;
  assign init_n     = (cfg_i.slot_count > CntMax) ? CntMax : cfg_i.slot_count;
  assign lent_inc   = lent_q + CountW'(1);
  assign cnt_inc    = init_cnt_q + CountW'(1);
  assign alloc_more = lent_inc < live_q;

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    idx_d        = idx_q;
    head_d       = head_q;
    head_valid_d = head_valid_q;
    lent_d       = lent_q;
    live_d       = live_q;
    pool_live_d  = pool_live_q;
    init_cnt_d   = init_cnt_q;
    init_n_d     = init_n_q;
    rsp_valid_d  = rsp_valid_q;
    status_d     = status_q;
    granted_d    = granted_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    load_rsp     = 1'b0;
    ld_status    = StOk;
    ld_granted   = '0;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          // The successor of the head is fetched speculatively for an alloc.
          mode_d  = mode_e'(req_i.mode);
          idx_d   = req_i.slot_index;
          mem_re  = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d  = S_IDLE;
          load_rsp = 1'b1;
          case (mode_q)
            ModeInit: begin
              if (init_n == '0) begin
                ld_status = StBadSlot;
              end else begin
                load_rsp   = 1'b0;
                init_cnt_d = '0;
                init_n_d   = init_n;
                state_d    = S_INIT;
              end
            end
            ModeRelease: begin
              if (lent_q != '0) begin
                ld_status = StInUse;
              end else begin
                pool_live_d  = 1'b0;
                head_valid_d = 1'b0;
                head_d       = '0;
                live_d       = '0;
              end
            end
            ModeAlloc: begin
              if (!pool_live_q) begin
                ld_status = StNotInit;
              end else if (!head_valid_q || lent_q >= live_q) begin
                ld_status = StExhausted;
              end else begin
                ld_granted   = SlotW'(head_q);
                lent_d       = lent_inc;
                head_valid_d = alloc_more;
                head_d       = alloc_more ? mem_rdata : '0;
              end
            end
            ModeFree: begin
              if (!pool_live_q) begin
                ld_status = StNotInit;
              end else if (CountW'(idx_q) >= live_q) begin
                ld_status = StBadSlot;
              end else if (lent_q == '0) begin
                ld_status = StNothingLent;
              end else begin
                mem_we       = 1'b1;
                mem_waddr    = AddrW'(idx_q);
                mem_wdata    = head_q;
                head_d       = AddrW'(idx_q);
                head_valid_d = 1'b1;
                lent_d       = lent_q - CountW'(1);
              end
            end
            default: ld_status = StOk;
          endcase
        end
      end
      S_INIT: begin
        // One link per cycle; the last slot links to slot 0 as its terminator.
        mem_we    = 1'b1;
        mem_waddr = AddrW'(init_cnt_q);
        mem_wdata = (cnt_inc < init_n_q) ? AddrW'(cnt_inc) : '0;
        if (cnt_inc == init_n_q) begin
          state_d = S_FIN;
        end else begin
          init_cnt_d = cnt_inc;
        end
      end
      S_FIN: begin
        if (out_free) begin
          head_d       = '0;
          head_valid_d = 1'b1;
          lent_d       = '0;
          live_d       = init_n_q;
          pool_live_d  = 1'b1;
          load_rsp     = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (load_rsp) begin
      rsp_valid_d = 1'b1;
      status_d    = ld_status;
      granted_d   = ld_granted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      head_valid_q <= 1'b0;
      lent_q       <= '0;
      live_q       <= '0;
      pool_live_q  <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
      lent_q       <= lent_d;
      live_q       <= live_d;
      pool_live_q  <= pool_live_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    idx_q      <= idx_d;
    init_cnt_q <= init_cnt_d;
    init_n_q   <= init_n_d;
    status_q   <= status_d;
    granted_q  <= granted_d;
  end

  a_lent_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lent_q <= live_q)
    else $error("lent count exceeds the live slot count");

  a_head_needs_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_q |-> pool_live_q)
    else $error("free list head valid on a dead pool");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("link memory read and written in the same cycle");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == S_EXEC))
    else $error("accepted request did not enter execution");

endmodule
`default_nettype wire

// ===== design/fixed_slot_free_list_manager_core.sv =====
`default_nettype none
// Fixed-slot free list manager. Each request transfer yields exactly one response transfer.
// Alloc, free and release go from acceptance through a registered read of the link memory at
// the current head to a step that decides and writes back. Init goes through the acceptance
// and decode steps, then strings slot_count links (slot_count saturated to MAX_SLOTS) through
// the single write port of the link memory, one slot per cycle, and ends with a closing step
// that brings the pool live. One request is worked on at a time; a finished response waits in
// an output register while the next request is taken, and a stalled receiver holds that next
// request in its decode step until the register frees.
// The link memory needs no clearing pass after reset: entries are only used once an init
// has written them. The slot count register sits at byte address 0 of the APB port and is
// sampled when an init starts, so writing it never disturbs a live pool.
// Depends on fslm_pkg, fslm_if, fslm_ram, fslm_cfg and fslm_engine.
module fixed_slot_free_list_manager_core #(
  parameter int unsigned MAX_SLOTS = fslm_pkg::MaxSlotsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fslm_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [fslm_pkg::CfgDataW-1:0] pwdata,
  output logic      [fslm_pkg::CfgDataW-1:0] prdata,
  output logic                               pready,
  fslm_req_if.sink                           req_i,
  fslm_rsp_if.source                         rsp_o
);
  import fslm_pkg::*;

  cfg_t cfg;

  // Configuration registers behind the APB port.
  fslm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer with the link memory; it owns both channels.
  fslm_engine #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule
`default_nettype wire

// ===== tb/fslm_tb_pkg.sv =====
// Scoreboard for the fixed-slot free list manager testbench: a slot pool predictor and the
// queue of pool answers it expects. Depends on fslm_pkg for widths, modes and status codes.
package fslm_tb_pkg;
  import fslm_pkg::*;

  localparam int unsigned PoolMax = MaxSlotsDefault;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] granted_slot;
  } pool_answer_t;

  class slot_pool_scoreboard;
    logic [SlotW-1:0]  link_mem [PoolMax];
    logic [SlotW-1:0]  head_slot;
    bit                head_valid;
    int unsigned       lent_count;
    int unsigned       live_count;
    bit                pool_live;
    logic [CountW-1:0] slot_count;
    pool_answer_t      answer_q[$];
    logic [SlotW-1:0]  lent_slots[$];
    int unsigned       mismatches;

    function new();
      foreach (link_mem[i]) link_mem[i] = '0;
      head_slot  = '0;
      head_valid = 1'b0;
      lent_count = 0;
      live_count = 0;
      pool_live  = 1'b0;
      slot_count = SlotCountReset;
      mismatches = 0;
    endfunction

    function void write_slot_count(logic [CountW-1:0] value);
      slot_count = value;
    endfunction

    function int unsigned pending();
      return answer_q.size();
    endfunction

    // Applies one accepted request to the pool copy and returns the answer it must produce.
    function pool_answer_t apply_request(mode_e mode, logic [SlotW-1:0] idx);
      pool_answer_t ans;
      int unsigned  n;
      int           hits[$];
      ans.status       = StOk;
      ans.granted_slot = '0;
      case (mode)
        ModeInit: begin
          n = (slot_count > PoolMax) ? PoolMax : slot_count;
          if (slot_count == 0) begin
            ans.status = StBadSlot;
          end else begin
            for (int unsigned i = 0; i + 1 < n; i++) link_mem[i] = SlotW'(i + 1);
            link_mem[n-1] = '0;
            head_slot  = '0;
            head_valid = 1'b1;
            lent_count = 0;
            live_count = n;
            pool_live  = 1'b1;
            lent_slots.delete();
          end
        end
        ModeAlloc: begin
          if (!pool_live) begin
            ans.status = StNotInit;
          end else if (!head_valid || lent_count >= live_count) begin
            ans.status = StExhausted;
          end else begin
            ans.granted_slot = head_slot;
            lent_count++;
            head_valid = lent_count < live_count;
            head_slot  = head_valid ? link_mem[ans.granted_slot] : '0;
            lent_slots.push_back(ans.granted_slot);
          end
        end
        ModeFree: begin
          if (!pool_live) begin
            ans.status = StNotInit;
          end else if (idx >= live_count) begin
            ans.status = StBadSlot;
          end else if (lent_count == 0) begin
            ans.status = StNothingLent;
          end else begin
            link_mem[idx] = head_slot;
            head_slot  = idx;
            head_valid = 1'b1;
            lent_count--;
            hits = lent_slots.find_first_index(s) with (s == idx);
            if (hits.size() != 0) lent_slots.delete(hits[0]);
          end
        end
        default: begin
          if (lent_count != 0) begin
            ans.status = StInUse;
          end else begin
            pool_live  = 1'b0;
            head_valid = 1'b0;
            head_slot  = '0;
            live_count = 0;
          end
        end
      endcase
      return ans;
    endfunction

    function void note_request(mode_e mode, logic [SlotW-1:0] idx);
      answer_q.push_back(apply_request(mode, idx));
    endfunction

    function void check_response(logic [StatusW-1:0] status, logic [SlotW-1:0] slot);
      pool_answer_t want;
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: status %0d slot %0d", status, slot);
        return;
      end
      want = answer_q.pop_front();
      if (status !== want.status || slot !== want.granted_slot) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response mismatch: status %0d slot %0d, expected status %0d slot %0d",
                   status, slot, want.status, want.granted_slot);
      end
    endfunction
  endclass

endpackage

// ===== tb/testbench.sv =====
// Top of the fixed-slot free list manager testbench: drives pool requests and slot count writes
// and checks every response against the slot pool predictor of fslm_tb_pkg.
// Depends on fslm_pkg, fslm_if, fslm_tb_pkg and fixed_slot_free_list_manager_core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fslm_pkg::*;
  import fslm_tb_pkg::*;

  localparam int unsigned ItemTarget = 1650;
  // Take a 256-slot init, add the long hold-off and the longest sender gap,
  // then take that several times over.
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned LongHold   = 80;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  fslm_req_if req ();
  fslm_rsp_if rsp ();

  fixed_slot_free_list_manager_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req),
    .rsp_o   (rsp)
  );

  slot_pool_scoreboard sb = new();

  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;
  bit          sender_gaps = 1'b1;
  bit          sender_idle = 1'b1;
  bit          hold_off_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one request and returns at the edge where it is accepted. The sender then either
  // keeps valid high for the next item or drops it for a random gap at the end of a burst.
  task automatic send_req(mode_e mode, logic [SlotW-1:0] idx);
    req.valid      <= 1'b1;
    req.mode       <= mode;
    req.slot_index <= idx;
    sender_idle = 1'b0;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sb.note_request(mode, idx);
    items_sent++;
    if (sender_gaps && burst_left == 0) begin
      req.valid <= 1'b0;
      sender_idle = 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 20);
    end else if (burst_left != 0) begin
      burst_left--;
    end
  endtask

  // Stops offering and waits until every predicted answer has come back, so the block is idle.
  task automatic drain_answers();
    if (!sender_idle) req.valid <= 1'b0;
    sender_idle = 1'b1;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // APB write of the slot count register: setup cycle, then access until pready.
  task automatic set_slot_count(logic [CountW-1:0] count);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'(4 * int'(RegSlotCount));
    pwdata  <= CfgDataW'(count);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_slot_count(count);
  endtask

  // Response side: every accepted transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) sb.check_response(rsp.status, rsp.granted_slot);
  end

  // Watchdog: counts cycles in which neither channel completes a transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Receiver: ready follows a stall pattern that changes every stretch. When the sender asks
  // for it, ready is held low for a long stretch so the block fills up and stalls its input.
  initial begin
    int unsigned stretch;
    int unsigned pattern;
    int unsigned tick;
    rsp.ready <= 1'b0;
    tick = 0;
    wait (rst_ni === 1'b1);
    forever begin
      stretch = $urandom_range(20, 200);
      pattern = $urandom_range(0, 3);
      repeat (stretch) begin
        @(posedge clk_i);
        tick++;
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          rsp.ready <= 1'b0;
          repeat (LongHold) @(posedge clk_i);
        end
        case (pattern)
          0: rsp.ready <= 1'b1;
          1: rsp.ready <= 1'($urandom_range(0, 1));
          2: rsp.ready <= ($urandom_range(0, 3) == 0);
          default: rsp.ready <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  initial begin
    int unsigned      phase;
    int unsigned      roll;
    int unsigned      phase_len;
    logic [CountW-1:0] count;
    logic [SlotW-1:0] last_freed;
    bit               have_freed;

    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    req.valid      <= 1'b0;
    req.mode       <= ModeAlloc;
    req.slot_index <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A dead pool after reset: alloc and free answer not initialized, and a
    // release of a pool that was never live is accepted and changes nothing.
    send_req(ModeAlloc, '0);
    send_req(ModeFree, '0);
    send_req(ModeRelease, '0);
    drain_answers();

    // A zero slot count makes init answer bad slot and leaves the pool untouched.
    set_slot_count('0);
    send_req(ModeInit, '0);
    drain_answers();

    // Two slots: grant both, run out, then walk the error paths of free and release. The
    // second free of slot 1 is a double free that the block cannot see while slot 0 is lent.
    set_slot_count(CountW'(2));
    send_req(ModeInit, '0);
    send_req(ModeAlloc, '0);
    send_req(ModeAlloc, '0);
    send_req(ModeAlloc, '0);
    send_req(ModeFree, 8'hFF);
    send_req(ModeRelease, '0);
    send_req(ModeFree, 8'd1);
    send_req(ModeFree, 8'd1);
    send_req(ModeFree, '0);
    send_req(ModeAlloc, '0);
    send_req(ModeAlloc, '0);
    // Init while slots are lent rebuilds the list; the release that follows then succeeds.
    send_req(ModeInit, '0);
    send_req(ModeRelease, '0);
    drain_answers();

    // Full pool: the top slot index is in range, and a free pushes it to the head.
    set_slot_count(CountW'(PoolMax));
    send_req(ModeInit, '0);
    send_req(ModeAlloc, '0);
    send_req(ModeFree, 8'hFF);
    send_req(ModeAlloc, '0);
    drain_answers();

    // A count above the pool size saturates; with nothing lent a free answers nothing lent.
    set_slot_count('1);
    send_req(ModeInit, '0);
    send_req(ModeFree, 8'hFF);
    drain_answers();

    // Single slot pool: one grant, then exhausted.
    set_slot_count(CountW'(1));
    send_req(ModeInit, '0);
    send_req(ModeAlloc, '0);
    send_req(ModeAlloc, '0);

    // Random part. Each phase drains the block, writes a new slot count and then runs a
    // well-formed stream of allocs and frees of lent slots, with some noise mixed in: frees of
    // random indexes, double frees, releases and re-inits. Most pools are small so that
    // exhaustion is reached often; a few use the largest counts.
    phase      = 0;
    have_freed = 1'b0;
    last_freed = '0;
    while (items_sent < ItemTarget) begin
      drain_answers();
      roll = $urandom_range(0, 99);
      if (roll < 2) count = '0;
      else if (roll < 70) count = CountW'($urandom_range(1, 12));
      else if (roll < 88) count = CountW'($urandom_range(13, 64));
      else if (roll < 96) count = CountW'($urandom_range(65, PoolMax));
      else count = CountW'($urandom_range(PoolMax + 1, (1 << CountW) - 1));
      set_slot_count(count);

      // The second phase is the pressure phase: the sender offers back to back while the
      // receiver holds off, so the block must stall its input.
      sender_gaps = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      burst_left  = $urandom_range(0, 20);
      send_req(ModeInit, SlotW'($urandom_range(0, 255)));
      // The hold-off starts once the init has answered, so that the waiting response and the
      // following requests back up behind the stalled receiver however long the init took.
      if (phase == 1) begin
        send_req(ModeAlloc, '0);
        hold_off_req = 1'b1;
      end

      phase_len = $urandom_range(40, 120);
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          send_req(ModeFree, SlotW'($urandom_range(0, 255)));
        end else if (roll < 6) begin
          send_req(ModeRelease, SlotW'($urandom_range(0, 255)));
        end else if (roll < 7) begin
          send_req(ModeInit, SlotW'($urandom_range(0, 255)));
        end else if (roll < 9 && have_freed) begin
          send_req(ModeFree, last_freed);
        end else if (roll < 50 && sb.lent_slots.size() != 0) begin
          last_freed = sb.lent_slots[$urandom_range(0, sb.lent_slots.size() - 1)];
          have_freed = 1'b1;
          send_req(ModeFree, last_freed);
        end else begin
          send_req(ModeAlloc, SlotW'($urandom_range(0, 255)));
        end
      end
      phase++;
    end

    drain_answers();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== fixed_slot_free_list_manager_core.f =====
design/fslm_pkg.sv
design/fslm_if.sv
design/fslm_ram.sv
design/fslm_cfg.sv
design/fslm_engine.sv
design/fixed_slot_free_list_manager_core.sv
tb/fslm_tb_pkg.sv
tb/testbench.sv
